// ----- design/sem_pkg.sv -----
// shared constants, register codes and state type for the sobel edge magnitude block
package sem_pkg;

    // pixel and result field widths
    localparam int PIX_W = 8;

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    // line store depth default
    localparam int MAX_WIDTH_DEF = 1024;

    // gradient and root datapath
    localparam int SUM_W   = 18;  // sum of two squared 8-bit values, padded to an even width
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int STEP_W  = $clog2(ROOT_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_ROOT,
        ST_DONE
    } state_t;

endpackage

// ----- design/sobel_edge_magnitude.sv -----
// Sobel 3x3 edge detector with gradient magnitude over two line memories
//
// Grey pixels arrive in raster order, one item per handshake. Two line
// memories hold the two rows above the current one and six window registers
// hold the two columns before it. An item is accepted only while the block is
// idle; the line memories are read in the cycle after acceptance and written
// back in that same cycle. A border pixel gives no result. An interior pixel
// passes through the accepting cycle, the read cycle, a state that squares the
// two gradients, the steps of a two-bit-per-step square root unit, and a
// state that rounds and hands the result to the output register, waiting
// while that register is full and stalled; the root unit sets the rate. The
// output register lets the next item be accepted while a result still waits
// to be taken. Writing either configuration register restarts the frame at
// row 0, column 0; line memory contents are kept and are not cleared after
// reset, so no clearing pass is needed.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data,
    // pixel items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sem_pkg::PIX_W-1:0]         pixel,
    // result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sem_pkg::PIX_W-1:0]         row_diff_abs,
    output logic [sem_pkg::PIX_W-1:0]         col_diff_abs,
    output logic [sem_pkg::PIX_W-1:0]         magnitude,
    output logic                              last_of_frame
);
    import sem_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (WIDTH_W > CW + 1) ? WIDTH_W : CW + 1;
    localparam int DW   = PIX_W + 4;  // signed weighted difference

    // registers
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CW-1:0]       col_reg;
    logic [HEIGHT_W-1:0] row_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic [PIX_W-1:0]    win_reg [6];
    logic [PIX_W-1:0]    ra_reg, ca_reg;
    logic                last_reg;
    logic [SUM_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg;
    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_row_reg, out_col_reg, out_mag_reg;
    logic                out_last_reg;
    state_t              state_reg, state_next;

    // line memories
    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] top_rd, mid_rd;

    // control from the state machine
    logic in_accept, mem_we, sq_load, root_step, out_load, cfg_hit;
    logic emit, col_last, row_last;

    assign in_accept = in_valid && !in_stall;
    assign cfg_hit   = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    // effective frame size
    logic [CMPW-1:0]     width_ext, eff_w;
    logic [HEIGHT_W-1:0] eff_h;

    assign width_ext = CMPW'(width_reg);

    always_comb
    begin
        if (width_ext < CMPW'(3))
            eff_w = CMPW'(3);
        else if (width_ext > CMPW'(MAX_WIDTH))
            eff_w = CMPW'(MAX_WIDTH);
        else
            eff_w = width_ext;
        eff_h = (height_reg < HEIGHT_W'(3)) ? HEIGHT_W'(3) : height_reg;
    end

    assign col_last = (CMPW'(col_reg) + CMPW'(1)) == eff_w;
    assign row_last = ({1'b0, row_reg} + (HEIGHT_W + 1)'(1)) == {1'b0, eff_h};
    assign emit     = (row_reg >= HEIGHT_W'(2)) && (col_reg >= CW'(2));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // column and row position, restarted by any register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_hit)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (mem_we)
        begin
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_reg + HEIGHT_W'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // line memories: read at the current column every cycle, written back in the read state
    always_ff @(posedge clk)
    begin
        if (mem_we)
            upper_mem[col_reg] <= mid_rd;
        top_rd <= upper_mem[col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            middle_mem[col_reg] <= pix_reg;
        mid_rd <= middle_mem[col_reg];
    end

    // captured pixel
    always_ff @(posedge clk)
    begin
        if (in_accept)
            pix_reg <= pixel;
    end

    // 3x3 window columns c-2 and c-1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (mem_we)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_rd;
            win_reg[4] <= mid_rd;
            win_reg[5] <= pix_reg;
        end
    end

    // weighted row and column differences
    logic [DW-1:0]        bot_sum, top_sum, right_sum, left_sum;
    logic signed [DW-1:0] rd, cd;
    logic [DW-1:0]        rd_abs, cd_abs;
    logic [PIX_W-1:0]     ra_sat, ca_sat;

    always_comb
    begin
        bot_sum   = DW'(win_reg[2]) + (DW'(win_reg[5]) << 1) + DW'(pix_reg);
        top_sum   = DW'(win_reg[0]) + (DW'(win_reg[3]) << 1) + DW'(top_rd);
        right_sum = DW'(top_rd) + (DW'(mid_rd) << 1) + DW'(pix_reg);
        left_sum  = DW'(win_reg[0]) + (DW'(win_reg[1]) << 1) + DW'(win_reg[2]);
        rd        = $signed(bot_sum) - $signed(top_sum);
        cd        = $signed(right_sum) - $signed(left_sum);
        rd_abs    = rd[DW-1] ? DW'(-rd) : DW'(rd);
        cd_abs    = cd[DW-1] ? DW'(-cd) : DW'(cd);
        ra_sat    = (rd_abs > DW'(255)) ? '1 : rd_abs[PIX_W-1:0];
        ca_sat    = (cd_abs > DW'(255)) ? '1 : cd_abs[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ra_reg   <= ra_sat;
            ca_reg   <= ca_sat;
            last_reg <= row_last && col_last;
        end
    end

    // square root, two radicand bits a step
    logic [REM_W-1:0] rem_shift, trial;
    logic [PIX_W:0]   mag_round;
    logic [PIX_W-1:0] mag_sat;

    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[SUM_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        if (sq_load)
        begin
            rad_next  = SUM_W'(16'(ra_reg) * 16'(ra_reg)) + SUM_W'(16'(ca_reg) * 16'(ca_reg));
            root_next = '0;
            rem_next  = '0;
        end
        else if (root_step)
        begin
            rad_next = {rad_reg[SUM_W-3:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (sq_load)
            step_reg <= '0;
        else if (root_step)
            step_reg <= step_reg + STEP_W'(1);
    end

    // round to nearest and saturate
    always_comb
    begin
        mag_round = (rem_reg > REM_W'(root_reg)) ? (PIX_W + 1)'(root_reg) + (PIX_W + 1)'(1)
                                                 : (PIX_W + 1)'(root_reg);
        mag_sat   = mag_round[PIX_W] ? '1 : mag_round[PIX_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_READ;
            ST_READ:   state_next = emit ? ST_SQUARE : ST_IDLE;
            ST_SQUARE: state_next = ST_ROOT;
            ST_ROOT:   if (step_reg == STEP_W'(ROOT_W - 1)) state_next = ST_DONE;
            ST_DONE:   if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state machine outputs
    always_comb
    begin
        in_stall  = 1'b1;
        mem_we    = 1'b0;
        sq_load   = 1'b0;
        root_step = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_stall  = 1'b0;
            ST_READ:   mem_we    = 1'b1;
            ST_SQUARE: sq_load   = 1'b1;
            ST_ROOT:   root_step = 1'b1;
            ST_DONE:   out_load  = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg  <= ra_reg;
            out_col_reg  <= ca_reg;
            out_mag_reg  <= mag_sat;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign row_diff_abs  = out_row_reg;
    assign col_diff_abs  = out_col_reg;
    assign magnitude     = out_mag_reg;
    assign last_of_frame = out_last_reg;

endmodule

// ----- design/sem_checker.sv -----
// port-level checks for the sobel edge magnitude block, bound to the top level
module sem_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [sem_pkg::PIX_W-1:0]     row_diff_abs,
    input logic [sem_pkg::PIX_W-1:0]     col_diff_abs,
    input logic [sem_pkg::PIX_W-1:0]     magnitude,
    input logic                          last_of_frame
);
    import sem_pkg::*;

    // a stalled result holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_diff_abs)
            && $stable(col_diff_abs) && $stable(magnitude) && $stable(last_of_frame))
        else $error("stalled result changed");

    // one item at a time: busy right after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    // a new result only appears while the block is busy finishing an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared from an idle block");

    // magnitude lies between the larger gradient and their sum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> magnitude >= row_diff_abs && magnitude >= col_diff_abs
            && {1'b0, magnitude} <= {1'b0, row_diff_abs} + {1'b0, col_diff_abs})
        else $error("magnitude out of bounds");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_diff_abs  (row_diff_abs),
    .col_diff_abs  (col_diff_abs),
    .magnitude     (magnitude),
    .last_of_frame (last_of_frame)
);

// ----- tb/sv/sobel_edge_magnitude_test.sv -----
// self-checking testbench for the sobel edge magnitude block: directed table, random frames, scoreboard
module sobel_edge_magnitude_test;
    import sem_pkg::*;

    localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int DIR_ROWS      = 22;

    typedef struct packed {
        logic [PIX_W-1:0] row_diff;
        logic [PIX_W-1:0] col_diff;
        logic [PIX_W-1:0] mag;
        logic             last_flag;
    } edge_result_t;

    typedef enum logic {
        ROW_PIXEL,
        ROW_WRITE
    } row_kind_t;

    typedef enum logic [1:0] {
        FILL_NOISE,
        FILL_BINARY,
        FILL_RAMP,
        FILL_DIM
    } fill_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      pix;
        logic                  typed;
        edge_result_t          result;
    } stim_row_t;

    // block ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel     = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_W-1:0]      row_diff_abs;
    logic [PIX_W-1:0]      col_diff_abs;
    logic [PIX_W-1:0]      magnitude;
    logic                  last_of_frame;

    // mirror of the block state
    logic [PIX_W-1:0] upper_mirror [LINE_DEPTH];
    logic [PIX_W-1:0] middle_mirror [LINE_DEPTH];
    logic [PIX_W-1:0] win [6];
    int               col_pos     = 0;
    int               row_pos     = 0;
    int               width_setting  = int'(WIDTH_RESET);
    int               height_setting = int'(HEIGHT_RESET);

    // scoreboard
    edge_result_t pending_edges [$];
    int           mismatches     = 0;
    int           results_seen   = 0;
    bit           sender_idle    = 1'b1;
    bit           receiver_idle  = 1'b1;
    stim_row_t    directed [DIR_ROWS];

    sobel_edge_magnitude #(
        .MAX_WIDTH(LINE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pixel(pixel),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .row_diff_abs(row_diff_abs),
        .col_diff_abs(col_diff_abs),
        .magnitude(magnitude),
        .last_of_frame(last_of_frame)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // widths below 3 behave as 3, above the line store depth as the depth
    function automatic int eff_width();
        if (width_setting < 3)
            return 3;
        if (width_setting > LINE_DEPTH)
            return LINE_DEPTH;
        return width_setting;
    endfunction

    function automatic int eff_height();
        return (height_setting < 3) ? 3 : height_setting;
    endfunction

    function automatic int clip_abs(input int v);
        int a;
        a = (v < 0) ? -v : v;
        return (a > 255) ? 255 : a;
    endfunction

    // gradient and magnitude for one pixel, advancing the mirrored state
    function automatic void predict_gradient(input logic [PIX_W-1:0] pix, output bit has_result,
                                             output edge_result_t res);
        int w, h, c, r;
        int tl, ml, bl, tm, bm, tr, mr, br;
        int rd, cd, ra, ca, sum_sq, root;
        logic [PIX_W-1:0] top_pix, mid_pix;
        w = eff_width();
        h = eff_height();
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        top_pix = upper_mirror[c];
        mid_pix = middle_mirror[c];
        res = '0;
        has_result = (r >= 2) && (c >= 2);
        if (has_result)
        begin
            tl = win[0];
            ml = win[1];
            bl = win[2];
            tm = win[3];
            bm = win[5];
            tr = top_pix;
            mr = mid_pix;
            br = pix;
            rd = (bl + 2 * bm + br) - (tl + 2 * tm + tr);
            cd = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
            ra = clip_abs(rd);
            ca = clip_abs(cd);
            sum_sq = ra * ra + ca * ca;
            // floor root by counting up, then round to nearest
            root = 0;
            while ((root + 1) * (root + 1) <= sum_sq)
                root++;
            if (sum_sq > root * root + root)
                root++;
            if (root > 255)
                root = 255;
            res.row_diff  = ra[PIX_W-1:0];
            res.col_diff  = ca[PIX_W-1:0];
            res.mag       = root[PIX_W-1:0];
            res.last_flag = (r == h - 1) && (c == w - 1);
        end
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top_pix;
        win[4] = mid_pix;
        win[5] = pix;
        upper_mirror[c]  = mid_pix;
        middle_mirror[c] = pix;
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    function automatic stim_row_t pixel_row(input logic [PIX_W-1:0] p);
        return '{ROW_PIXEL, '0, '0, p, 1'b0, '0};
    endfunction

    function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] d);
        return '{ROW_WRITE, idx, d, '0, 1'b0, '0};
    endfunction

    function automatic stim_row_t checked_row(input logic [PIX_W-1:0] p, input int rd,
                                              input int cd, input int m, input bit lf);
        edge_result_t e;
        e.row_diff  = rd[PIX_W-1:0];
        e.col_diff  = cd[PIX_W-1:0];
        e.mag       = m[PIX_W-1:0];
        e.last_flag = lf;
        return '{ROW_PIXEL, '0, '0, p, 1'b1, e};
    endfunction

    // offer one pixel item, after a random gap when sender_idle is set, and log what it should produce
    task automatic send_pixel(input logic [PIX_W-1:0] p, input bit typed,
                              input edge_result_t typed_res);
        int gap;
        bit has_result;
        edge_result_t pred;
        gap = sender_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predict_gradient(p, has_result, pred);
        if (typed)
            pending_edges.push_back(typed_res);
        else if (has_result)
            pending_edges.push_back(pred);
    endtask

    // drop valid, drain all results and let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_setting = int'(d[WIDTH_W-1:0]);
        else
            height_setting = int'(d[HEIGHT_W-1:0]);
        // any register write restarts the frame
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic send_burst(input int count, input fill_t fill);
        int k;
        logic [PIX_W-1:0] p;
        for (k = 0; k < count; k++)
        begin
            case (fill)
                FILL_NOISE:  p = PIX_W'($urandom_range(0, 255));
                FILL_BINARY: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                FILL_RAMP:   p = PIX_W'(k * 9 + $urandom_range(0, 6));
                default:     p = PIX_W'($urandom_range(0, 15));
            endcase
            send_pixel(p, 1'b0, '0);
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        int k, w, h, n, order, random_sent;
        for (k = 0; k < LINE_DEPTH; k++)
        begin
            upper_mirror[k]  = '0;
            middle_mirror[k] = '0;
        end
        for (k = 0; k < 6; k++)
            win[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset setting, undersized registers, saturation both ways, frame wrap
        directed = '{
            pixel_row(8'd17), pixel_row(8'd200),
            write_row(REG_IMAGE_WIDTH, 16'h0000), write_row(REG_IMAGE_HEIGHT, 16'h0001),
            pixel_row(8'd0), pixel_row(8'd0), pixel_row(8'd0),
            pixel_row(8'd0), pixel_row(8'd0), pixel_row(8'd0),
            pixel_row(8'd255), pixel_row(8'd255), checked_row(8'd255, 255, 0, 255, 1'b1),
            pixel_row(8'd255), pixel_row(8'd0), pixel_row(8'd0),
            pixel_row(8'd255), pixel_row(8'd0), pixel_row(8'd0),
            pixel_row(8'd255), pixel_row(8'd0), checked_row(8'd0, 0, 255, 255, 1'b1)
        };
        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (directed[k].kind == ROW_WRITE)
                write_reg(directed[k].index, directed[k].data);
            else
                send_pixel(directed[k].pix, directed[k].typed, directed[k].result);
        end

        // random frames of small sizes, registers rewritten between bursts
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            k = $urandom_range(0, 19);
            if (k < 2)
                w = $urandom_range(0, 2);
            else if (k < 16)
                w = $urandom_range(3, 10);
            else
                w = $urandom_range(11, 40);
            k = $urandom_range(0, 19);
            if (k < 2)
                h = $urandom_range(0, 2);
            else if (k < 17)
                h = $urandom_range(3, 8);
            else if (k < 19)
                h = $urandom_range(9, 30);
            else
                h = $urandom_range(1000, 65535);
            order = $urandom_range(0, 3);
            if (order != 3)
                write_reg(REG_IMAGE_WIDTH, {5'($urandom), 11'(w)});
            if (order != 2)
                write_reg(REG_IMAGE_HEIGHT, 16'(h));
            n = eff_width() * eff_height();
            if (n > 120)
                n = 120;
            n = n * $urandom_range(1, 2) + $urandom_range(0, eff_width());
            sender_idle = ($urandom_range(0, 3) != 0);
            send_burst(n, fill_t'($urandom_range(0, 3)));
            random_sent += n;
        end

        // the tallest frame on the narrowest line
        sender_idle = 1'b1;
        write_reg(REG_IMAGE_WIDTH, 16'h0003);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        send_burst(90, FILL_NOISE);

        settle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // result side: random stalls, two long hold-offs, in-order comparison
    initial
    begin : result_side
        int hold;
        edge_result_t got, want;
        forever
        begin
            if (results_seen == 100 || results_seen == 300)
                hold = LONG_HOLD;
            else
                hold = receiver_idle ? $urandom_range(0, 8) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            got = {row_diff_abs, col_diff_abs, magnitude, last_of_frame};
            results_seen++;
            if (results_seen % 64 == 0)
                receiver_idle = ($urandom_range(0, 3) != 0);
            if (pending_edges.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d with nothing expected: row %0d col %0d mag %0d last %0b",
                             results_seen, got.row_diff, got.col_diff, got.mag, got.last_flag);
            end
            else
            begin
                want = pending_edges.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: exp %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                                 results_seen, want.row_diff, want.col_diff, want.mag,
                                 want.last_flag, got.row_diff, got.col_diff, got.mag,
                                 got.last_flag);
                end
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sem_pkg.sv
design/sobel_edge_magnitude.sv
design/sem_checker.sv
tb/sv/sobel_edge_magnitude_test.sv
